// ===== hw/rtl/spm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier package
// Shared widths, sizes and the structs passed between the product generator,
// the accumulator cells and the top level.
// ----------------------------------------------------------------------------
package spm_pkg;

   localparam int MAX_TERMS   = 8;
   localparam int COEFF_WIDTH = 16;

   localparam int IN_CW      = 16;
   localparam int EXP_W      = 10;
   localparam int SUM_EXP_W  = 11;
   localparam int SUM_W      = 38;
   localparam int STORE_CW   = (COEFF_WIDTH < IN_CW) ? COEFF_WIDTH : IN_CW;
   localparam int PROD_W     = 2 * STORE_CW;
   localparam int CNT_W      = $clog2(MAX_TERMS + 1);
   localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CELL_COUNT = MAX_TERMS * MAX_TERMS;

   // One partial product or one accumulated result term.
   typedef struct packed {
      logic                        valid;
      logic [SUM_EXP_W-1:0]        exponent;
      logic signed [SUM_W-1:0]     coefficient;
   } spm_item_type;

   // Requests from the top level to the product generator.
   typedef struct packed {
      logic                        load;
      logic                        kind;
      logic signed [IN_CW-1:0]     coefficient;
      logic [EXP_W-1:0]            exponent;
      logic                        start_job;
      logic                        clear_counts;
   } spm_gen_ctrl_type;

   // Status from the product generator.
   typedef struct packed {
      logic                        counts_nonzero;
      logic                        pairs_done;
   } spm_gen_stat_type;

endpackage

// ===== hw/rtl/spm_pair_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier product generator
// Stores the terms of both polynomials and walks over every pair, producing
// one registered product with its summed exponent per cycle.
// ----------------------------------------------------------------------------
module spm_pair_gen
   import spm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  spm_gen_ctrl_type ctrl,
   output spm_gen_stat_type stat,
   output spm_item_type     product
);

   logic signed [STORE_CW-1:0] first_coeffs_ff  [MAX_TERMS];
   logic [EXP_W-1:0]           first_exps_ff    [MAX_TERMS];
   logic signed [STORE_CW-1:0] second_coeffs_ff [MAX_TERMS];
   logic [EXP_W-1:0]           second_exps_ff   [MAX_TERMS];

   logic [CNT_W-1:0] first_count_ff;
   logic [CNT_W-1:0] second_count_ff;
   logic [IDX_W-1:0] i_ff;
   logic [IDX_W-1:0] j_ff;
   logic             run_ff;

   logic signed [STORE_CW-1:0] a_ff;
   logic signed [STORE_CW-1:0] b_ff;
   logic [SUM_EXP_W-1:0]       e1_ff;
   logic                       v1_ff;

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic [SUM_EXP_W-1:0]       e2_ff;
   logic                       v2_ff;

   logic last_j;
   logic last_i;

   assign last_j = ((CNT_W'(j_ff) + CNT_W'(1)) == second_count_ff);
   assign last_i = ((CNT_W'(i_ff) + CNT_W'(1)) == first_count_ff);

   assign stat.counts_nonzero = (first_count_ff != '0) && (second_count_ff != '0);
   assign stat.pairs_done     = run_ff && last_i && last_j;

   assign prod_in = PROD_W'(a_ff) * PROD_W'(b_ff);

   // Term stores.
   always_ff @(posedge clock) begin
      if (ctrl.load && !ctrl.kind && (first_count_ff < CNT_W'(MAX_TERMS))) begin
         first_coeffs_ff[first_count_ff[IDX_W-1:0]] <= ctrl.coefficient[STORE_CW-1:0];
         first_exps_ff[first_count_ff[IDX_W-1:0]]   <= ctrl.exponent;
      end
      if (ctrl.load && ctrl.kind && (second_count_ff < CNT_W'(MAX_TERMS))) begin
         second_coeffs_ff[second_count_ff[IDX_W-1:0]] <= ctrl.coefficient[STORE_CW-1:0];
         second_exps_ff[second_count_ff[IDX_W-1:0]]   <= ctrl.exponent;
      end
   end

   // Counts and the pair walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         run_ff          <= 1'b0;
         i_ff            <= '0;
         j_ff            <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
      end else begin
         if (ctrl.clear_counts) begin
            first_count_ff  <= '0;
            second_count_ff <= '0;
         end else if (ctrl.load) begin
            if (!ctrl.kind && (first_count_ff < CNT_W'(MAX_TERMS))) begin
               first_count_ff <= first_count_ff + CNT_W'(1);
            end
            if (ctrl.kind && (second_count_ff < CNT_W'(MAX_TERMS))) begin
               second_count_ff <= second_count_ff + CNT_W'(1);
            end
         end

         if (ctrl.start_job) begin
            run_ff <= 1'b1;
            i_ff   <= '0;
            j_ff   <= '0;
         end else if (run_ff) begin
            if (last_j) begin
               j_ff <= '0;
               i_ff <= i_ff + IDX_W'(1);
               if (last_i) begin
                  run_ff <= 1'b0;
               end
            end else begin
               j_ff <= j_ff + IDX_W'(1);
            end
         end

         v1_ff <= run_ff;
         v2_ff <= v1_ff;
      end
   end

   // Operand and product registers carry no reset.
   always_ff @(posedge clock) begin
      a_ff    <= first_coeffs_ff[i_ff];
      b_ff    <= second_coeffs_ff[j_ff];
      e1_ff   <= {1'b0, first_exps_ff[i_ff]} + {1'b0, second_exps_ff[j_ff]};
      prod_ff <= prod_in;
      e2_ff   <= e1_ff;
   end

   assign product.valid       = v2_ff;
   assign product.exponent    = e2_ff;
   assign product.coefficient = SUM_W'(prod_ff);

endmodule

// ===== hw/rtl/spm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier accumulator cell
// One slot of a sorted chain: merges, swaps or forwards a travelling term,
// and shifts toward the head while results are read out.
// ----------------------------------------------------------------------------
module spm_cell
   import spm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift,
   input  spm_item_type carry_in,
   input  spm_item_type right_entry,
   output spm_item_type entry,
   output spm_item_type carry_out
);

   spm_item_type entry_ff;
   spm_item_type entry_in;
   spm_item_type carry_ff;
   spm_item_type carry_in_next;

   always_comb begin
      entry_in            = entry_ff;
      carry_in_next       = carry_in;
      carry_in_next.valid = 1'b0;
      if (shift) begin
         entry_in = right_entry;
      end else if (carry_in.valid) begin
         if (!entry_ff.valid) begin
            entry_in = carry_in;
         end else if (entry_ff.exponent == carry_in.exponent) begin
            entry_in.coefficient = entry_ff.coefficient + carry_in.coefficient;
         end else if (carry_in.exponent > entry_ff.exponent) begin
            entry_in      = carry_in;
            carry_in_next = entry_ff;
         end else begin
            carry_in_next = carry_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         carry_ff <= carry_in_next;
      end
   end

   assign entry     = entry_ff;
   assign carry_out = carry_ff;

endmodule

// ===== hw/rtl/sparse_polynomial_multiplier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier
// Multiplies two sparse polynomials loaded term by term and streams out the
// product terms in descending exponent order.
// ----------------------------------------------------------------------------
// Usage:
//   An item is one term, taken when start is high and busy is low. req_kind
//   picks the polynomial; terms beyond MAX_TERMS per polynomial are dropped.
//   A non-final term yields nothing.
//   The term with req_last_term set launches the job and raises busy. If
//   either polynomial is empty, busy stays high for one cycle and no result
//   comes out.
//   Otherwise every pair is issued to a chain of CELL_COUNT accumulator
//   cells, one pair per cycle; each travelling product moves one cell per
//   cycle, merging with an equal exponent or pushing smaller entries back,
//   so the chain stays sorted. After a drain the chain shifts toward its
//   head, one result per cycle on rsp_valid, with rsp_last_result on the
//   lowest exponent.
//   Job time is set by the pair walk, the chain length and the readout shift.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   Synchronous reset empties the chain and clears the term counts.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiplier_unit
   import spm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_kind,
   input  logic signed [IN_CW-1:0] req_coefficient,
   input  logic [EXP_W-1:0]        req_exponent,
   input  logic                    req_last_term,
   output logic                    rsp_valid,
   output logic signed [SUM_W-1:0] rsp_sum_coefficient,
   output logic [SUM_EXP_W-1:0]    rsp_sum_exponent,
   output logic                    rsp_last_result
);

   // Long enough for a product issued last to settle at the far end of the chain.
   localparam int DRAIN_CYCLES = CELL_COUNT + 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic [DRAIN_W-1:0]     drain_ff;
   logic                   rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_coeff_ff;
   logic [SUM_EXP_W-1:0]   rsp_exp_ff;
   logic                   rsp_last_ff;

   logic             accept;
   spm_gen_ctrl_type gen_ctrl;
   spm_gen_stat_type gen_stat;
   spm_item_type     product;

   spm_item_type     entries [CELL_COUNT+1];
   spm_item_type     carries [CELL_COUNT];
   logic             shift;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign shift  = (state_ff == ST_EMIT);

   always_comb begin
      gen_ctrl.load         = accept;
      gen_ctrl.kind         = req_kind;
      gen_ctrl.coefficient  = req_coefficient;
      gen_ctrl.exponent     = req_exponent;
      gen_ctrl.start_job    = (state_ff == ST_CHECK) && gen_stat.counts_nonzero;
      gen_ctrl.clear_counts = ((state_ff == ST_CHECK) && !gen_stat.counts_nonzero) ||
                              ((state_ff == ST_MULT) && gen_stat.pairs_done);
   end

   spm_pair_gen u_pair_gen (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (gen_ctrl),
      .stat    (gen_stat),
      .product (product)
   );

   // The slot past the tail reads as empty, so the chain drains cleanly.
   assign entries[CELL_COUNT] = '0;

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      spm_item_type cin;
      if (k == 0) begin : g_head
         assign cin = product;
      end else begin : g_body
         assign cin = carries[k-1];
      end
      spm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (shift),
         .carry_in    (cin),
         .right_entry (entries[k+1]),
         .entry       (entries[k]),
         .carry_out   (carries[k])
      );
   end

   // Sequencer and registered result port.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_last_term) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (gen_stat.counts_nonzero) begin
                  state_ff <= ST_MULT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MULT: begin
               drain_ff <= '0;
               if (gen_stat.pairs_done) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + DRAIN_W'(1);
               if (drain_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (entries[0].valid) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= !entries[1].valid;
               end
               if (!entries[0].valid || !entries[1].valid) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_coeff_ff <= entries[0].coefficient;
      rsp_exp_ff   <= entries[0].exponent;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sum_coefficient = rsp_coeff_ff;
   assign rsp_sum_exponent    = rsp_exp_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule

// ===== hw/rtl/spm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier checker
// Port-level properties of the result stream and the busy flag.
// ----------------------------------------------------------------------------
module spm_checker
   import spm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 req_last_term,
   input logic                 rsp_valid,
   input logic [SUM_EXP_W-1:0] rsp_sum_exponent,
   input logic                 rsp_last_result
);

   // Results only come out of a job in progress.
   a_rsp_in_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result outside a job");

   // A job's results form one unbroken burst.
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid)
      else $error("gap in result burst");

   // Exponents fall strictly within a burst.
   a_descending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_sum_exponent < $past(rsp_sum_exponent))
      else $error("result exponents not descending");

   // A plain term load never makes the block busy.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_term |=> !busy)
      else $error("busy after a non-final term");

endmodule

bind sparse_polynomial_multiplier_unit spm_checker u_spm_checker (.*);

// ===== test/tb_sparse_polynomial_multiplier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier testbench
// Loads term sequences into the multiplier and predicts every product term
// that each job should emit. It checks each emitted term, in order and field
// by field, against that prediction. A directed part covers the extreme
// values, zero sums, empty polynomials and the full term store. A random
// part then runs jobs of mixed sizes under bursty start traffic.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_multiplier_unit
   import spm_pkg::*;
();

   // One emitted product term as the block should present it.
   typedef struct {
      logic signed [SUM_W-1:0]  coefficient;
      logic [SUM_EXP_W-1:0]     exponent;
      logic                     final_term;
   } product_term_type;

   localparam int EXP_SLOTS = 2 ** SUM_EXP_W;

   // All inputs start at known values; reset is held from time zero.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_kind = 1'b0;
   logic signed [IN_CW-1:0] req_coefficient = '0;
   logic [EXP_W-1:0]        req_exponent = '0;
   logic                    req_last_term = 1'b0;
   logic                    rsp_valid;
   logic signed [SUM_W-1:0] rsp_sum_coefficient;
   logic [SUM_EXP_W-1:0]    rsp_sum_exponent;
   logic                    rsp_last_result;

   sparse_polynomial_multiplier_unit uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_coefficient     (req_coefficient),
      .req_exponent        (req_exponent),
      .req_last_term       (req_last_term),
      .rsp_valid           (rsp_valid),
      .rsp_sum_coefficient (rsp_sum_coefficient),
      .rsp_sum_exponent    (rsp_sum_exponent),
      .rsp_last_result     (rsp_last_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The predictor keeps its own copy of both term stores and their counts.
   logic signed [IN_CW-1:0] first_coeff  [MAX_TERMS];
   logic [EXP_W-1:0]        first_exp    [MAX_TERMS];
   logic signed [IN_CW-1:0] second_coeff [MAX_TERMS];
   logic [EXP_W-1:0]        second_exp   [MAX_TERMS];
   int                      first_count  = 0;
   int                      second_count = 0;

   // Per-exponent accumulation for one job, indexed directly by exponent.
   longint                  exp_sum [EXP_SLOTS];
   bit                      exp_hit [EXP_SLOTS];

   product_term_type        expected_terms [$];
   product_term_type        oldest_term;

   int                      mismatch_count = 0;
   int                      items_sent     = 0;
   int                      burst_left     = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("MISMATCH at %0t ns: %s", $realtime, what);
      end
   endtask

   // Applies one accepted term to the predicted state. A final term, with both
   // stores non-empty, forms every pairwise product, sums them per exponent and
   // queues one expected term per exponent, highest first, with the lowest one marked final.
   task automatic predict_term(input bit kind, input logic signed [IN_CW-1:0] coef,
                               input logic [EXP_W-1:0] exp, input bit last);
      logic signed [IN_CW-1:0] stored;
      product_term_type        term;
      int                      e;
      int                      produced;

      // The store keeps only STORE_CW bits, sign-extended from that width.
      stored = coef <<< (IN_CW - STORE_CW);
      stored = stored >>> (IN_CW - STORE_CW);

      // Terms beyond the store depth are dropped silently.
      if (!kind) begin
         if (first_count < MAX_TERMS) begin
            first_coeff[first_count] = stored;
            first_exp[first_count]   = exp;
            first_count++;
         end
      end else begin
         if (second_count < MAX_TERMS) begin
            second_coeff[second_count] = stored;
            second_exp[second_count]   = exp;
            second_count++;
         end
      end

      if (last) begin
         // With either polynomial empty the job emits nothing at all.
         if (first_count != 0 && second_count != 0) begin
            for (e = 0; e < EXP_SLOTS; e++) begin
               exp_hit[e] = 1'b0;
            end
            for (int i = 0; i < first_count; i++) begin
               for (int j = 0; j < second_count; j++) begin
                  e = int'(first_exp[i]) + int'(second_exp[j]);
                  if (!exp_hit[e]) begin
                     exp_hit[e] = 1'b1;
                     exp_sum[e] = 0;
                  end
                  exp_sum[e] += longint'(first_coeff[i]) * longint'(second_coeff[j]);
               end
            end
            produced = 0;
            for (e = EXP_SLOTS - 1; e >= 0; e--) begin
               if (exp_hit[e]) begin
                  term.coefficient = exp_sum[e][SUM_W-1:0];
                  term.exponent    = e[SUM_EXP_W-1:0];
                  term.final_term  = 1'b0;
                  expected_terms.push_back(term);
                  produced++;
               end
            end
            if (produced > 0) begin
               expected_terms[expected_terms.size() - 1].final_term = 1'b1;
            end
         end
         first_count  = 0;
         second_count = 0;
      end
   endtask

   // Sends one term. The sender works in bursts: when a burst runs out,
   // start drops for a random gap before the next burst begins. Busy is
   // sampled at the falling edge, so the item is taken at the next rising
   // edge when busy was low there. The task returns in the time step of that
   // accepting edge and leaves start high, so a following item keeps start
   // asserted without a lower-and-raise in one step.
   task automatic send_term(input bit kind, input logic signed [IN_CW-1:0] coef,
                            input logic [EXP_W-1:0] exp, input bit last);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // Now and then a long burst gives a stretch with no idling at all.
         burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 12);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_coefficient <= coef;
      req_exponent    <= exp;
      req_last_term   <= last;
      do begin
         @(negedge clock);
      end while (busy !== 1'b0);
      @(posedge clock);
      predict_term(kind, coef, exp, last);
      burst_left--;
      items_sent++;
   endtask

   // Holds the sender off until every predicted term has been emitted.
   task automatic pause_for_results();
      start <= 1'b0;
      wait (expected_terms.size() == 0);
      @(posedge clock);
   endtask

   // Extreme coefficients and exponents. The middle exponent cancels to a
   // zero sum, which must still be emitted; the top one reaches 2046.
   task automatic test_extreme_terms();
      send_term(1'b0, -16'sd32768, 10'd1023, 1'b0);
      send_term(1'b0, -16'sd32768, 10'd0,    1'b0);
      send_term(1'b1,  16'sd32767, 10'd1023, 1'b0);
      send_term(1'b1, -16'sd32767, 10'd0,    1'b1);
   endtask

   // Nine terms per polynomial: the ninth of each is dropped, and the
   // dropped second-polynomial term carries last_term and must still start
   // the job. The exponents are spread so that all 64 sums are distinct.
   task automatic test_full_store();
      for (int i = 0; i <= MAX_TERMS; i++) begin
         send_term(1'b0, (i == MAX_TERMS) ? -16'sd32768 : IN_CW'(i + 1),
                   EXP_W'(i * MAX_TERMS), 1'b0);
      end
      for (int j = 0; j <= MAX_TERMS; j++) begin
         send_term(1'b1, (j == MAX_TERMS) ? 16'sd32767 : IN_CW'(j - 3),
                   EXP_W'(j), j == MAX_TERMS);
      end
   endtask

   // Jobs where one polynomial has no terms emit nothing but still clear
   // the counts; the next job would expose counts that had survived.
   task automatic test_empty_polynomial();
      send_term(1'b0, 16'sd5,   10'd3, 1'b0);
      send_term(1'b0, -16'sd7,  10'd9, 1'b1);
      send_term(1'b1, 16'sd100, 10'd4, 1'b1);
   endtask

   // Random jobs. Most are well formed with one to four terms per side and
   // sometimes a full store; some leave a polynomial empty and some overfill
   // a store. Narrow exponent windows force many products onto the same
   // exponent, and small coefficients make zero sums likely.
   task automatic test_random_jobs();
      int                      first_item;
      int                      n1;
      int                      n2;
      int                      k1;
      int                      k2;
      int                      mode;
      int                      exp_base;
      bit                      kind;
      bit                      narrow_exp;
      bit                      small_coef;
      bit                      paused_once;
      logic signed [IN_CW-1:0] coef;
      logic [EXP_W-1:0]        exp;

      first_item  = items_sent;
      paused_once = 1'b0;
      while (items_sent - first_item < 275) begin
         mode = $urandom_range(0, 9);
         n1   = ($urandom_range(0, 5) == 0) ? MAX_TERMS : $urandom_range(1, 4);
         n2   = ($urandom_range(0, 5) == 0) ? MAX_TERMS : $urandom_range(1, 4);
         if (mode == 0) begin
            if ($urandom_range(0, 1) == 1) begin
               n1 = 0;
            end else begin
               n2 = 0;
            end
         end else if (mode == 1) begin
            n1 = $urandom_range(MAX_TERMS, MAX_TERMS + 3);
            n2 = $urandom_range(1, MAX_TERMS + 3);
         end
         narrow_exp = 1'($urandom_range(0, 1));
         small_coef = ($urandom_range(0, 3) == 0);
         exp_base   = ($urandom_range(0, 1) == 1) ? 1016 : 0;
         k1 = 0;
         k2 = 0;
         while (k1 < n1 || k2 < n2) begin
            if (k1 == n1) begin
               kind = 1'b1;
            end else if (k2 == n2) begin
               kind = 1'b0;
            end else begin
               kind = 1'($urandom_range(0, 1));
            end
            if (kind) begin
               k2++;
            end else begin
               k1++;
            end
            coef = small_coef ? IN_CW'(int'($urandom_range(0, 6)) - 3)
                              : IN_CW'($urandom_range(0, 65535));
            exp  = narrow_exp ? EXP_W'(exp_base + int'($urandom_range(0, 7)))
                              : EXP_W'($urandom_range(0, 1023));
            send_term(kind, coef, exp, k1 == n1 && k2 == n2);
         end
         // The first pause is certain; later ones happen now and then.
         if (!paused_once || $urandom_range(0, 9) == 0) begin
            pause_for_results();
            paused_once = 1'b1;
         end
      end
   endtask

   // Results cannot be held off, so every strobe is checked at the falling
   // edge, in the middle of the cycle in which it is shown.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_terms.size() == 0) begin
               report_mismatch($sformatf("unexpected term exp %0d coeff %0d",
                                         rsp_sum_exponent, rsp_sum_coefficient));
            end else begin
               oldest_term = expected_terms.pop_front();
               if (rsp_sum_exponent !== oldest_term.exponent) begin
                  report_mismatch($sformatf("exponent %0d, expected %0d",
                                            rsp_sum_exponent, oldest_term.exponent));
               end
               if (rsp_sum_coefficient !== oldest_term.coefficient) begin
                  report_mismatch($sformatf("coefficient %0d at exp %0d, expected %0d",
                                            rsp_sum_coefficient, oldest_term.exponent,
                                            oldest_term.coefficient));
               end
               if (rsp_last_result !== oldest_term.final_term) begin
                  report_mismatch($sformatf("last flag %b at exp %0d, expected %b",
                                            rsp_last_result, oldest_term.exponent,
                                            oldest_term.final_term));
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("result strobe is unknown");
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_extreme_terms();
      test_full_store();
      test_empty_polynomial();
      test_random_jobs();

      // Let the last job drain, then watch a while longer for stray terms.
      start <= 1'b0;
      wait (expected_terms.size() == 0);
      repeat (250) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // A correct run takes well under a millisecond; this bound is five times that.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
